// ===== src/caseless_substring_search_top_assert.svh =====
// Assertion macros for the caseless substring search block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CASELESS_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`define CASELESS_SUBSTRING_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define CSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/css_pkg.sv =====
// Shared types, constants and case folding for the caseless substring search.
// No dependencies.
`timescale 1ns / 1ps

package css_pkg;

  localparam int PAT_BYTES       = 16;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int TEXT_SIZE_DEF   = 1048576;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int POS_W   = 20;
  localparam int END_W   = 21;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  localparam logic [BYTE_W-1:0] LOW_A      = 8'h61;
  localparam logic [BYTE_W-1:0] LOW_Z      = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_SHIFT = 8'h20;

  typedef enum logic [IDX_W-1:0] {
    REG_PATTERN_LEN  = 3'd0,
    REG_PATTERN_LOW  = 3'd1,
    REG_PATTERN_HIGH = 3'd2,
    REG_BACKWARD     = 3'd3,
    REG_SCAN_FROM    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_PRIMARY = 2'd0,
    ST_WRAP    = 2'd1,
    ST_NONE    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // one compare result travelling from the cell row to the tracker
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
    logic prim;
  } step_t;

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= LOW_A && c <= LOW_Z) begin
      r = c - CASE_SHIFT;
    end
    return r;
  endfunction

endpackage

// ===== src/caseless_substring_search_top.sv =====
// Top level of the caseless substring search: config registers, history cell row, counters.
// Depends on css_pkg, css_cell, css_track and the assertion macro header.
//
//  channel | direction | transfer when            | payload
//  in      | input     | in_valid && !in_stall    | in_text_byte, in_last_byte
//  out     | output    | out_valid && !out_stall  | out_status, out_match_start, out_match_end
//  cfg     | input     | cfg_we                   | cfg_index, cfg_data
//
// One text byte per cycle while in_stall is low; the cell row shifts once per counted byte.
// The result of a text passes the compare stage, the tracker stage and the pending register to the output register.
// Reset (synchronous) clears the config registers, the byte count and all hit tracking.
// Input stalls only while one result waits under out_stall in the output register and a second behind it.
`timescale 1ns / 1ps
`include "caseless_substring_search_top_assert.svh"

module caseless_substring_search_top #(
  parameter int MAX_PATTERN = css_pkg::MAX_PATTERN_DEF,
  parameter int TEXT_SIZE   = css_pkg::TEXT_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [css_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [css_pkg::POS_W-1:0]     out_match_start,
  output logic [css_pkg::END_W-1:0]     out_match_end,
  input  logic                          cfg_we,
  input  logic [css_pkg::IDX_W-1:0]     cfg_index,
  input  logic [css_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NC = (MAX_PATTERN < css_pkg::PAT_BYTES) ? MAX_PATTERN : css_pkg::PAT_BYTES;
  localparam int CW = $clog2(TEXT_SIZE + 1);
  localparam int KW = (CW > css_pkg::POS_W) ? CW : css_pkg::POS_W;

  logic [css_pkg::LEN_W-1:0]  plen_r;
  logic [css_pkg::CFG_W-1:0]  plow_r, phigh_r;
  logic                       bwd_r;
  logic [css_pkg::POS_W-1:0]  from_r;

  logic [css_pkg::LEN_W-1:0]  len;
  logic [css_pkg::PAT_BYTES*css_pkg::BYTE_W-1:0] pat_raw, pat_fold;

  logic [CW-1:0] cnt_r, cnt_inc, cnt1_r;
  logic          v1_r, last1_r, live1_r;
  logic          hold, acc, live;

  logic [css_pkg::BYTE_W-1:0] chain [NC+1];
  logic [NC-1:0]              eq_vec;

  css_pkg::step_t step;
  logic [CW-1:0]  start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      plow_r  <= '0;
      phigh_r <= '0;
      bwd_r   <= 1'b0;
      from_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        css_pkg::REG_PATTERN_LEN:  plen_r  <= cfg_data[css_pkg::LEN_W-1:0];
        css_pkg::REG_PATTERN_LOW:  plow_r  <= cfg_data;
        css_pkg::REG_PATTERN_HIGH: phigh_r <= cfg_data;
        css_pkg::REG_BACKWARD:     bwd_r   <= cfg_data[0];
        css_pkg::REG_SCAN_FROM:    from_r  <= cfg_data[css_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len = (plen_r > css_pkg::LEN_W'(NC)) ? css_pkg::LEN_W'(NC) : plen_r;
    pat_raw = {phigh_r, plow_r};
    for (int b = 0; b < css_pkg::PAT_BYTES; b++) begin
      pat_fold[b*css_pkg::BYTE_W +: css_pkg::BYTE_W] =
        css_pkg::fold(pat_raw[b*css_pkg::BYTE_W +: css_pkg::BYTE_W]);
    end
  end

  assign in_stall = hold;
  assign acc      = in_valid && !hold;
  assign live     = cnt_r < CW'(TEXT_SIZE);
  assign cnt_inc  = cnt_r + CW'(1);
  assign chain[0] = css_pkg::fold(in_text_byte);

  for (genvar k = 0; k < NC; k++) begin : g_cell
    css_cell #(
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .shift (acc && live),
      .din   (chain[k]),
      .pat   (pat_fold),
      .len   (len),
      .dout  (chain[k+1]),
      .eq    (eq_vec[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      live1_r <= 1'b0;
    end else begin
      if (acc) begin
        if (in_last_byte) begin
          cnt_r <= '0;
        end else if (live) begin
          cnt_r <= cnt_inc;
        end
      end
      if (!hold) begin
        v1_r    <= acc;
        last1_r <= in_last_byte;
        live1_r <= live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      cnt1_r <= live ? cnt_inc : cnt_r;
    end
  end

  always_comb begin
    start     = cnt1_r - CW'(len);
    step.vld  = v1_r;
    step.last = last1_r;
    step.hit  = live1_r && (len != '0) && (cnt1_r >= CW'(len)) && (&eq_vec);
    step.prim = bwd_r ? (KW'(start) <= KW'(from_r)) : (KW'(start) >= KW'(from_r));
  end

  css_track #(
    .CW (CW)
  ) u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .start           (start),
    .len             (len),
    .backward        (bwd_r),
    .scan_from       (from_r),
    .hold            (hold),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_match_start (out_match_start),
    .out_match_end   (out_match_end)
  );

  `CSS_ASSERT_NEXT(a_cnt_clear, clk, rst_n, acc && in_last_byte, cnt_r == '0, "byte count not cleared at text end")
  `CSS_ASSERT_NEXT(a_step_vld, clk, rst_n, acc, v1_r, "accepted byte missing from compare stage")
  `CSS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(TEXT_SIZE), "byte count past text size")

endmodule

// ===== src/css_cell.sv =====
// One history cell: holds a folded text byte and whether it matches its pattern byte.
// Depends on css_pkg.
`timescale 1ns / 1ps

module css_cell #(
  parameter int IDX = 0
) (
  input  logic                                         clk,
  input  logic                                         shift,
  input  logic [css_pkg::BYTE_W-1:0]                   din,
  input  logic [css_pkg::PAT_BYTES*css_pkg::BYTE_W-1:0] pat,
  input  logic [css_pkg::LEN_W-1:0]                    len,
  output logic [css_pkg::BYTE_W-1:0]                   dout,
  output logic                                         eq
);

  logic [css_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                       eq_r, eq_nxt;
  logic [css_pkg::LEN_W-1:0]  sel_full;
  logic [3:0]                 sel;
  logic                       active;

  // cell IDX lines up with pattern byte len-1-IDX
  always_comb begin
    sel_full = len - css_pkg::LEN_W'(IDX + 1);
    sel      = sel_full[3:0];
    active   = len > css_pkg::LEN_W'(IDX);
    byte_nxt = din;
    eq_nxt   = !active || (din == pat[sel*css_pkg::BYTE_W +: css_pkg::BYTE_W]);
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= byte_nxt;
      eq_r   <= eq_nxt;
    end
  end

  assign dout = byte_r;
  assign eq   = eq_r;

endmodule

// ===== src/css_track.sv =====
// Match tracker: keeps primary and wrap hits per text and forms the result.
// Depends on css_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "caseless_substring_search_top_assert.svh"

module css_track #(
  parameter int CW = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  css_pkg::step_t                step,
  input  logic [CW-1:0]                 start,
  input  logic [css_pkg::LEN_W-1:0]     len,
  input  logic                          backward,
  input  logic [css_pkg::POS_W-1:0]     scan_from,
  output logic                          hold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [css_pkg::POS_W-1:0]     out_match_start,
  output logic [css_pkg::END_W-1:0]     out_match_end
);

  localparam int EW = (CW > css_pkg::END_W ? CW : css_pkg::END_W) + 1;

  logic           v2_r, last2_r, hit2_r, prim2_r;
  logic [CW-1:0]  s2_r;
  logic           pf_r, wf_r, pf_nxt, wf_nxt;
  logic [CW-1:0]  ph_r, wh_r, ph_nxt, wh_nxt;
  logic           fin_v_r, fin_pf_r, fin_wf_r;
  logic [CW-1:0]  fin_ph_r, fin_wh_r;
  logic           out_v_r;
  logic [1:0]     st_r, st_nxt;
  logic [css_pkg::POS_W-1:0] ms_r, ms_nxt;
  logic [css_pkg::END_W-1:0] me_r, me_nxt;
  logic           en, fin_take, fin_load;
  logic [CW-1:0]  sel_hit;
  logic [EW-1:0]  end_sum;

  assign hold     = fin_v_r && out_v_r && out_stall;
  assign en       = !hold;
  assign fin_take = fin_v_r && (!out_v_r || !out_stall);
  assign fin_load = en && v2_r && last2_r;

  always_comb begin
    pf_nxt = pf_r;
    wf_nxt = wf_r;
    ph_nxt = ph_r;
    wh_nxt = wh_r;
    if (v2_r && hit2_r) begin
      if (prim2_r) begin
        if (backward || !pf_r) begin
          pf_nxt = 1'b1;
          ph_nxt = s2_r;
        end
      end else begin
        if (backward || !wf_r) begin
          wf_nxt = 1'b1;
          wh_nxt = s2_r;
        end
      end
    end
  end

  always_comb begin
    sel_hit = fin_pf_r ? fin_ph_r : fin_wh_r;
    end_sum = EW'(sel_hit) + EW'(len);
    if (len == '0) begin
      st_nxt = css_pkg::ST_EMPTY;
      ms_nxt = scan_from;
      me_nxt = css_pkg::END_W'(scan_from);
    end else if (fin_pf_r || fin_wf_r) begin
      st_nxt = fin_pf_r ? css_pkg::ST_PRIMARY : css_pkg::ST_WRAP;
      ms_nxt = css_pkg::POS_W'(sel_hit);
      me_nxt = css_pkg::END_W'(end_sum);
    end else begin
      st_nxt = css_pkg::ST_NONE;
      ms_nxt = '0;
      me_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
      hit2_r  <= 1'b0;
      prim2_r <= 1'b0;
      pf_r    <= 1'b0;
      wf_r    <= 1'b0;
      ph_r    <= '0;
      wh_r    <= '0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en) begin
        v2_r    <= step.vld;
        last2_r <= step.last;
        hit2_r  <= step.hit;
        prim2_r <= step.prim;
        if (v2_r) begin
          if (last2_r) begin
            pf_r <= 1'b0;
            wf_r <= 1'b0;
            ph_r <= '0;
            wh_r <= '0;
          end else begin
            pf_r <= pf_nxt;
            wf_r <= wf_nxt;
            ph_r <= ph_nxt;
            wh_r <= wh_nxt;
          end
        end
      end
      if (fin_load) begin
        fin_v_r <= 1'b1;
      end else if (fin_take) begin
        fin_v_r <= 1'b0;
      end
      if (fin_take) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= start;
    end
    if (fin_load) begin
      fin_pf_r <= pf_nxt;
      fin_wf_r <= wf_nxt;
      fin_ph_r <= ph_nxt;
      fin_wh_r <= wh_nxt;
    end
    if (fin_take) begin
      st_r <= st_nxt;
      ms_r <= ms_nxt;
      me_r <= me_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = st_r;
  assign out_match_start = ms_r;
  assign out_match_end   = me_r;

  `CSS_ASSERT_NEXT(a_fin_load, clk, rst_n, fin_load, fin_v_r && !pf_r && !wf_r, "text end not captured")
  `CSS_ASSERT_NEXT(a_fin_keep, clk, rst_n, hold, fin_v_r, "pending result lost under stall")
  `CSS_ASSERT(a_none_zero, clk, rst_n, out_v_r && out_status == css_pkg::ST_NONE |-> out_match_start == '0 && out_match_end == '0, "no-match result not zero")

endmodule

// ===== sim/tb_caseless_substring_search_top.sv =====
// Testbench for caseless_substring_search_top: streams texts, predicts the search result per text.
// Self-checking against an in-file predictor; depends on css_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_caseless_substring_search_top;

  localparam int TEXT_BYTES   = 1048576;
  localparam int PAT_MAX      = 16;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_NS     = 2000000;

  localparam logic [7:0]  CH_LO_A  = "a";
  localparam logic [7:0]  CH_LO_Z  = "z";
  localparam logic [7:0]  CASE_BIT = 8'h20;
  // "@", backquote, "[", "{", "A", "Z", "a", "z"
  localparam logic [63:0] BOUNDARY = 64'h4060_5B7B_415A_617A;
  localparam logic [css_pkg::IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_item_t;

  typedef struct packed {
    css_pkg::status_t          st;
    logic [css_pkg::POS_W-1:0] first;
    logic [css_pkg::END_W-1:0] past;
  } hit_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [css_pkg::BYTE_W-1:0] in_text_byte = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [css_pkg::POS_W-1:0] out_match_start;
  logic [css_pkg::END_W-1:0] out_match_end;
  logic cfg_we = 1'b0;
  logic [css_pkg::IDX_W-1:0] cfg_index = '0;
  logic [css_pkg::CFG_W-1:0] cfg_data = '0;

  caseless_substring_search_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_match_start (out_match_start),
    .out_match_end   (out_match_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow and scan state of the predictor
  logic [4:0]                pat_len_r = '0;
  logic [63:0]               pat_lo_r = '0;
  logic [63:0]               pat_hi_r = '0;
  logic                      back_r = 1'b0;
  logic [css_pkg::POS_W-1:0] from_r = '0;
  logic [7:0]                hist_m [PAT_MAX];
  logic [css_pkg::END_W-1:0] seen_m, prim_at, wrap_at;
  logic                      prim_ok, wrap_ok;

  text_item_t  pend_q[$];
  hit_report_t want_q[$];
  text_item_t  cur;
  logic        offering = 1'b0;
  int          errors = 0;
  int          rand_items = 0;
  int          send_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_done = 0;
  int          hold_left = 0;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      return c - CASE_BIT;
    end
    return c;
  endfunction

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    if (lc >= CH_LO_A && lc <= CH_LO_Z) begin
      return c ^ CASE_BIT;
    end
    return c;
  endfunction

  function automatic int used_len();
    return (pat_len_r > PAT_MAX) ? PAT_MAX : int'(pat_len_r);
  endfunction

  function automatic logic [7:0] pat_at(input int k);
    logic [127:0] w;
    w = {pat_hi_r, pat_lo_r};
    return w[8*k +: 8];
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    logic [7:0] c;
    r = $urandom_range(15);
    if (r == 0) begin
      c = 8'($urandom_range(255));
    end else if (r < 4) begin
      c = BOUNDARY[8*$urandom_range(7) +: 8];
    end else begin
      c = CH_LO_A + 8'($urandom_range(2));
      if ($urandom_range(1)) c = c ^ CASE_BIT;
    end
    return c;
  endfunction

  task automatic clear_scan();
    foreach (hist_m[i]) hist_m[i] = '0;
    seen_m  = '0;
    prim_at = '0;
    wrap_at = '0;
    prim_ok = 1'b0;
    wrap_ok = 1'b0;
  endtask

  task automatic apply_reg(input logic [css_pkg::IDX_W-1:0] idx,
                           input logic [css_pkg::CFG_W-1:0] d);
    case (idx)
      css_pkg::REG_PATTERN_LEN:  pat_len_r = d[4:0];
      css_pkg::REG_PATTERN_LOW:  pat_lo_r = d;
      css_pkg::REG_PATTERN_HIGH: pat_hi_r = d;
      css_pkg::REG_BACKWARD:     back_r = d[0];
      css_pkg::REG_SCAN_FROM:    from_r = d[css_pkg::POS_W-1:0];
      default: ;
    endcase
  endtask

  // one accepted text byte: shift history, judge the candidate ending here, report on last
  task automatic scan_byte(input text_item_t it);
    int n, i, j;
    logic [css_pkg::END_W-1:0] s;
    logic hit;
    hit_report_t r;
    n = used_len();
    if (seen_m < TEXT_BYTES) begin
      for (i = PAT_MAX - 1; i > 0; i--) hist_m[i] = hist_m[i-1];
      hist_m[0] = it.data;
      seen_m = seen_m + 1'b1;
      if (n > 0 && seen_m >= n) begin
        s = seen_m - css_pkg::END_W'(n);
        hit = 1'b1;
        for (j = 0; j < n; j++) begin
          if (upcase(pat_at(j)) != upcase(hist_m[n-1-j])) hit = 1'b0;
        end
        if (hit) begin
          if (!back_r) begin
            if (s >= {1'b0, from_r}) begin
              if (!prim_ok) begin
                prim_ok = 1'b1;
                prim_at = s;
              end
            end else if (!wrap_ok) begin
              wrap_ok = 1'b1;
              wrap_at = s;
            end
          end else if (s <= {1'b0, from_r}) begin
            prim_ok = 1'b1;
            prim_at = s;
          end else begin
            wrap_ok = 1'b1;
            wrap_at = s;
          end
        end
      end
    end
    if (it.last) begin
      if (n == 0) begin
        r = '{css_pkg::ST_EMPTY, from_r, {1'b0, from_r}};
      end else if (prim_ok) begin
        r = '{css_pkg::ST_PRIMARY, prim_at[css_pkg::POS_W-1:0],
              css_pkg::END_W'(prim_at + n)};
      end else if (wrap_ok) begin
        r = '{css_pkg::ST_WRAP, wrap_at[css_pkg::POS_W-1:0],
              css_pkg::END_W'(wrap_at + n)};
      end else begin
        r = '{css_pkg::ST_NONE, '0, '0};
      end
      want_q.push_back(r);
      clear_scan();
    end
  endtask

  initial clear_scan();

  // input side: transfer bookkeeping at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      scan_byte(cur);
      offering = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!offering && pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      cur = pend_q.pop_front();
      offering = 1'b1;
      in_valid <= 1'b1;
      in_text_byte <= cur.data;
      in_last_byte <= cur.last;
    end else if (!offering) begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left == 0 && hold_done != hold_req) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    hit_report_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d start %0d end %0d",
                 $time, out_status, out_match_start, out_match_end);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (out_status !== w.st) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, w.st, out_status);
          errors++;
        end
        if (out_match_start !== w.first) begin
          $display("%0t: match_start mismatch, expected %0d, got %0d",
                   $time, w.first, out_match_start);
          errors++;
        end
        if (out_match_end !== w.past) begin
          $display("%0t: match_end mismatch, expected %0d, got %0d",
                   $time, w.past, out_match_end);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(input logic [css_pkg::IDX_W-1:0] idx,
                           input logic [css_pkg::CFG_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, d);
  endtask

  task automatic wait_quiet();
    while (pend_q.size() != 0 || offering || want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_literal(input string s);
    int k;
    for (k = 0; k < s.len(); k++) begin
      pend_q.push_back(text_item_t'{data: s[k], last: (k == s.len() - 1)});
    end
  endtask

  // random text, often carrying case-swapped copies of the pattern
  task automatic queue_text(input int n, input bit close);
    int p, k, plen;
    logic [7:0] b;
    p = 0;
    plen = used_len();
    while (p < n) begin
      if (plen > 0 && p + plen <= n && $urandom_range(3) == 0) begin
        for (k = 0; k < plen; k++) begin
          b = pat_at(k);
          if ($urandom_range(1)) b = swap_case(b);
          if ($urandom_range(15) == 0) b = pick_byte();
          pend_q.push_back(text_item_t'{data: b, last: close && p == n - 1});
          p++;
        end
      end else begin
        pend_q.push_back(text_item_t'{data: pick_byte(), last: close && p == n - 1});
        p++;
      end
    end
    rand_items += n;
  endtask

  task automatic random_group();
    int r, t, texts, k;
    logic [4:0] len;
    logic [63:0] d, lo, hi;
    wait_quiet();
    r = $urandom_range(9);
    if (r == 0) len = '0;
    else if (r == 1) len = 5'($urandom_range(17, 31));
    else if (r == 2) len = 5'($urandom_range(7, 16));
    else len = 5'($urandom_range(1, 6));
    for (k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pick_byte();
      hi[8*k +: 8] = pick_byte();
    end
    d = {$urandom, $urandom};
    d[4:0] = len;
    reg_write(css_pkg::REG_PATTERN_LEN, d);
    reg_write(css_pkg::REG_PATTERN_LOW, lo);
    reg_write(css_pkg::REG_PATTERN_HIGH, hi);
    reg_write(css_pkg::REG_BACKWARD, {$urandom, $urandom});
    d = {$urandom, $urandom};
    r = $urandom_range(7);
    if (r == 0) d[css_pkg::POS_W-1:0] = '0;
    else if (r == 1) d[css_pkg::POS_W-1:0] = '1;
    else d[css_pkg::POS_W-1:0] = css_pkg::POS_W'($urandom_range(30));
    reg_write(css_pkg::REG_SCAN_FROM, d);
    if ($urandom_range(7) == 0) begin
      reg_write(css_pkg::IDX_W'(REG_UNUSED_FIRST + $urandom_range(2)), {$urandom, $urandom});
    end
    texts = $urandom_range(1, 3);
    for (t = 0; t < texts; t++) begin
      queue_text($urandom_range(1, 24), (t < texts - 1) || ($urandom_range(7) != 0));
    end
  endtask

  initial begin
    #(LIMIT_NS);
    $display("caseless_substring_search_top test failed");
    $finish;
  end

  initial begin
    int k;
    send_idle_pct = 32;
    rcv_idle_pct = 58;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: ignored indexes, empty pattern at both scan_from extremes
    for (k = 0; k < 3; k++) reg_write(css_pkg::IDX_W'(REG_UNUSED_FIRST + k), '1);
    pend_q.push_back(text_item_t'{data: 8'hFF, last: 1'b1});
    wait_quiet();
    reg_write(css_pkg::REG_SCAN_FROM, '1);
    pend_q.push_back(text_item_t'{data: 8'h00, last: 1'b1});
    wait_quiet();

    // two-byte pattern, forward hit ending at the last byte
    reg_write(css_pkg::REG_PATTERN_LEN, 64'd2);
    reg_write(css_pkg::REG_PATTERN_LOW, {48'hC3A5_96F0_5A3C, "Ba"});
    reg_write(css_pkg::REG_PATTERN_HIGH, '1);
    reg_write(css_pkg::REG_SCAN_FROM, '0);
    queue_literal("zAb");
    wait_quiet();
    // backward: one hit at or before scan_from, one after
    reg_write(css_pkg::REG_BACKWARD, 64'd1);
    reg_write(css_pkg::REG_SCAN_FROM, 64'd1);
    queue_literal("abab");
    queue_literal("a");
    wait_quiet();

    // oversized length clamps to sixteen bytes
    reg_write(css_pkg::REG_BACKWARD, '0);
    reg_write(css_pkg::REG_PATTERN_LEN, 64'd31);
    // "QmZa", "{", backquote, "[", "@"
    reg_write(css_pkg::REG_PATTERN_LOW, 64'h516D_5A61_7B60_5B40);
    reg_write(css_pkg::REG_PATTERN_HIGH, "pK0~_?Az");
    for (k = 0; k < PAT_MAX; k++) begin
      pend_q.push_back(text_item_t'{data: swap_case(pat_at(k)), last: k == PAT_MAX - 1});
    end

    rand_items = 0;
    while (rand_items < 420) random_group();

    wait_quiet();
    send_idle_pct = 58;
    rcv_idle_pct = 32;
    while (rand_items < 840) random_group();

    wait_quiet();
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    // long receiver hold-off while short texts keep coming
    hold_req++;
    for (k = 0; k < 60; k++) queue_text(1, 1'b1);
    while (rand_items < 1250) random_group();
    queue_literal("!");
    wait_quiet();

    if (errors == 0) begin
      $display("caseless_substring_search_top test passed");
    end else begin
      $display("caseless_substring_search_top test failed");
    end
    $finish;
  end

endmodule
